[rtl/core/ssc_pkg.sv]
package ssc_pkg;

	localparam int MAX_SLOTS   = 32;
	localparam int NUM_SPRITES = 128;
	localparam int SLOT_AW     = $clog2(MAX_SLOTS);
	localparam int CNT_W       = 6;
	localparam int SPR_W       = 7;
	localparam int PAT_AW      = SPR_W + 4;

	localparam logic [2:0] MODE_PATTERN = 3'd0;
	localparam logic [2:0] MODE_TRANSP  = 3'd1;
	localparam logic [2:0] MODE_SLOT    = 3'd2;
	localparam logic [2:0] MODE_COUNT   = 3'd3;
	localparam logic [2:0] MODE_SORT    = 3'd4;
	localparam logic [2:0] MODE_RENDER  = 3'd5;

	typedef enum logic [2:0] {
		RA_J, RA_JM1, RA_KM2, RA_WL, RA_WF, RA_K
	} rd_sel_t;

	typedef struct packed {
		logic [15:0]      y;
		logic [15:0]      x;
		logic [SPR_W-1:0] spr;
		logic [7:0]       depth;
		logic             blink;
	} slot_t;

	typedef struct packed {
		logic    wr_pat;
		logic    wr_trn;
		logic    wr_slot;
		logic    set_cnt;
		logic    ld_line;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    ld_key;
		logic    wr_key;
		logic    wr_shift;
		logic    j_init;
		logic    j_inc;
		logic    k_from_j;
		logic    k_dec;
		logic    k_from_wf;
		logic    k_inc;
		logic    win_clr;
		logic    wl_inc;
		logic    wf_inc;
		logic    pix_rd;
		logic    out_pix;
		logic    out_done;
	} cmd_t;

	typedef struct packed {
		logic j_lt_cnt;
		logic k_zero;
		logic key_before;
		logic wl_lt_cnt;
		logic wf_lt_cnt;
		logic y_le_line;
		logic y_le_lm16;
		logic k_lt_wl;
		logic cnt_zero;
		logic draw_ok;
		logic out_busy;
	} stat_t;

endpackage

[rtl/core/sprite_scanline_compositor.sv]
// Sprite scanline compositor.
// Input channel (in_valid/in_ready) takes one word per command: mode 0 writes
// a 16-pixel pattern row, 1 a transparent code, 2 a draw-list slot, 3 the
// slot count, 4 sorts the list by row then depth, 5 renders one line.
// Output channel (out_valid/out_ready) returns, for mode 5 only, one word per
// visible slot (x_start, colors, write_mask, bright) and a closing word with
// done_res set. Other modes return nothing.
// Commands are taken one at a time. A sort's length grows with each listed
// slot past the first and each shifted slot, set by the single read port of
// the draw-list RAM. A line first advances the window, then checks each
// slot in it, skipping or drawing it, and ends with the done word.
// The first pixel word follows the window advance steps and any skipped
// slots ahead of it.
// Reset clears slot count, window and handshake state; pattern, code and
// slot stores hold garbage until written (no clearing pass).
// A stall on out_ready holds the output register, and the controller waits
// before it loads the next word; no words are dropped.
module sprite_scanline_compositor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         mode,
	input  logic [6:0]         sprite_number,
	input  logic [3:0]         pattern_row,
	input  logic [63:0]        row_pixels,
	input  logic [5:0]         slot,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_x,
	input  logic [7:0]         depth,
	input  logic               blink,
	input  logic [4:0]         transparent_code,
	input  logic [15:0]        frame_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] x_start,
	output logic [63:0]        colors,
	output logic [15:0]        write_mask,
	output logic               bright,
	output logic               done_res
);
	import ssc_pkg::*;

	cmd_t  cmd;
	stat_t st;

	// sequencer: decodes commands, walks sort and window loops
	ssc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// stores, counters, compare logic and output register
	ssc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.sprite_number    (sprite_number),
		.pattern_row      (pattern_row),
		.row_pixels       (row_pixels),
		.slot             (slot),
		.pos_y            (pos_y),
		.pos_x            (pos_x),
		.depth            (depth),
		.blink            (blink),
		.transparent_code (transparent_code),
		.frame_count      (frame_count),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.x_start          (x_start),
		.colors           (colors),
		.write_mask       (write_mask),
		.bright           (bright),
		.done_res         (done_res)
	);
endmodule

[rtl/core/ssc_ctrl.sv]
module ssc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [2:0]    mode,
	output logic          in_ready,
	input  ssc_pkg::stat_t st,
	output ssc_pkg::cmd_t  cmd
);
	import ssc_pkg::*;

	typedef enum logic [3:0] {
		IDLE, S_J, S_KEY, S_CMP, R_START, R_WL_RD, R_WL_CMP, R_WF_RD, R_WF_CMP,
		R_K_RD, R_K_CHK, R_K_PIX, R_DONE
	} state_t;

	state_t state_q, state_d;
	logic   acc;

	assign in_ready = (state_q == IDLE);
	assign acc      = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			IDLE: begin
				if (acc) begin
					unique case (mode)
						MODE_PATTERN: cmd.wr_pat = 1'b1;
						MODE_TRANSP:  cmd.wr_trn = 1'b1;
						MODE_SLOT:    cmd.wr_slot = 1'b1;
						MODE_COUNT:   cmd.set_cnt = 1'b1;
						MODE_SORT: begin
							cmd.j_init = 1'b1;
							state_d    = S_J;
						end
						MODE_RENDER: begin
							cmd.ld_line = 1'b1;
							state_d     = R_START;
						end
						default: ;
					endcase
				end
			end
			S_J: begin
				if (st.j_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_J;
					state_d    = S_KEY;
				end else begin
					cmd.win_clr = 1'b1;
					state_d     = IDLE;
				end
			end
			S_KEY: begin
				cmd.ld_key   = 1'b1;
				cmd.k_from_j = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = RA_JM1;
				state_d      = S_CMP;
			end
			S_CMP: begin
				if (!st.k_zero && st.key_before) begin
					cmd.wr_shift = 1'b1;
					cmd.k_dec    = 1'b1;
					cmd.rd_en    = 1'b1;
					cmd.rd_sel   = RA_KM2;
				end else begin
					cmd.wr_key = 1'b1;
					cmd.j_inc  = 1'b1;
					state_d    = S_J;
				end
			end
			R_START: state_d = st.cnt_zero ? R_DONE : R_WL_RD;
			R_WL_RD: begin
				if (st.wl_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_WL;
					state_d    = R_WL_CMP;
				end else begin
					state_d = R_WF_RD;
				end
			end
			R_WL_CMP: begin
				if (st.y_le_line) begin
					cmd.wl_inc = 1'b1;
					state_d    = R_WL_RD;
				end else begin
					state_d = R_WF_RD;
				end
			end
			R_WF_RD: begin
				if (st.wf_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_WF;
					state_d    = R_WF_CMP;
				end else begin
					cmd.k_from_wf = 1'b1;
					state_d       = R_K_RD;
				end
			end
			R_WF_CMP: begin
				if (st.y_le_lm16) begin
					cmd.wf_inc = 1'b1;
					state_d    = R_WF_RD;
				end else begin
					cmd.k_from_wf = 1'b1;
					state_d       = R_K_RD;
				end
			end
			R_K_RD: begin
				if (st.k_lt_wl) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_K;
					state_d    = R_K_CHK;
				end else begin
					state_d = R_DONE;
				end
			end
			R_K_CHK: begin
				if (st.draw_ok) begin
					cmd.pix_rd = 1'b1;
					state_d    = R_K_PIX;
				end else begin
					cmd.k_inc = 1'b1;
					state_d   = R_K_RD;
				end
			end
			R_K_PIX: begin
				if (!st.out_busy) begin
					cmd.out_pix = 1'b1;
					cmd.k_inc   = 1'b1;
					state_d     = R_K_RD;
				end
			end
			R_DONE: begin
				if (!st.out_busy) begin
					cmd.out_done = 1'b1;
					state_d      = IDLE;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a word is only loaded into the output register when it is free
	a_pix_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_pix || cmd.out_done) |-> !st.out_busy)
		else $error("output load while stalled");
	a_pix_after_chk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == R_K_PIX) |-> $past(cmd.pix_rd))
		else $error("pixel state without pattern read");
	a_sort_exit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.win_clr |=> in_ready)
		else $error("sort did not return to idle");
endmodule

[rtl/core/ssc_dp.sv]
module ssc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  ssc_pkg::cmd_t       cmd,
	output ssc_pkg::stat_t      st,
	input  logic [6:0]          sprite_number,
	input  logic [3:0]          pattern_row,
	input  logic [63:0]         row_pixels,
	input  logic [5:0]          slot,
	input  logic signed [15:0]  pos_y,
	input  logic signed [15:0]  pos_x,
	input  logic [7:0]          depth,
	input  logic                blink,
	input  logic [4:0]          transparent_code,
	input  logic [15:0]         frame_count,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [16:0]  x_start,
	output logic [63:0]         colors,
	output logic [15:0]         write_mask,
	output logic                bright,
	output logic                done_res
);
	import ssc_pkg::*;

	logic [63:0]        pat_mem [NUM_SPRITES*16];
	logic [4:0]         trn_mem [NUM_SPRITES];
	slot_t              slot_mem [MAX_SLOTS];

	logic [CNT_W-1:0]   cnt_q, wl_q, wf_q, j_q, k_q;
	slot_t              rd_q, key_q;
	logic [63:0]        pat_q;
	logic [4:0]         trn_q;
	logic [15:0]        line_q, px_x_q;
	logic               phase_q, px_blink_q;
	logic               out_valid_q;
	logic signed [16:0] x_start_q;
	logic [63:0]        colors_q;
	logic [15:0]        mask_q;
	logic               bright_q, done_q;

	logic [CNT_W-1:0]   ra_full;
	logic [SLOT_AW-1:0] rd_addr, wr_addr;
	logic               slot_we;
	slot_t              wr_data;
	logic signed [16:0] line17, y17, rd_y17, key_y17, row17;
	logic [15:0]        mask_c;
	logic               spr_ok_w;

	assign spr_ok_w = 32'(sprite_number) < NUM_SPRITES;

	// pattern and transparent code stores
	always_ff @(posedge clk) begin
		if (cmd.wr_pat && spr_ok_w)
			pat_mem[{sprite_number, pattern_row}] <= row_pixels;
		if (cmd.pix_rd)
			pat_q <= pat_mem[PAT_AW'({rd_q.spr, row17[3:0]})];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_trn && spr_ok_w)
			trn_mem[sprite_number] <= transparent_code;
		if (cmd.pix_rd)
			trn_q <= trn_mem[rd_q.spr];
	end

	// draw list store: one write, one registered read per cycle
	always_comb begin
		case (cmd.rd_sel)
			RA_J:    ra_full = j_q;
			RA_JM1:  ra_full = j_q - CNT_W'(1);
			RA_KM2:  ra_full = k_q - CNT_W'(2);
			RA_WL:   ra_full = wl_q;
			RA_WF:   ra_full = wf_q;
			RA_K:    ra_full = k_q;
			default: ra_full = k_q;
		endcase
	end
	assign rd_addr = ra_full[SLOT_AW-1:0];

	always_comb begin
		slot_we = 1'b0;
		wr_addr = k_q[SLOT_AW-1:0];
		wr_data = key_q;
		if (cmd.wr_slot) begin
			slot_we       = 32'(slot) < MAX_SLOTS;
			wr_addr       = slot[SLOT_AW-1:0];
			wr_data.y     = pos_y;
			wr_data.x     = pos_x;
			wr_data.spr   = sprite_number;
			wr_data.depth = depth;
			wr_data.blink = blink;
		end else if (cmd.wr_shift) begin
			slot_we = 1'b1;
			wr_data = rd_q;
		end else if (cmd.wr_key) begin
			slot_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we)
			slot_mem[wr_addr] <= wr_data;
		if (cmd.rd_en)
			rd_q <= slot_mem[rd_addr];
	end

	// payload holding registers
	always_ff @(posedge clk) begin
		if (cmd.ld_key)
			key_q <= rd_q;
		if (cmd.ld_line) begin
			line_q  <= pos_y;
			phase_q <= frame_count[3];
		end
		if (cmd.pix_rd) begin
			px_x_q     <= rd_q.x;
			px_blink_q <= rd_q.blink;
		end
	end

	// counters and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wl_q  <= '0;
			wf_q  <= '0;
			j_q   <= '0;
			k_q   <= '0;
		end else begin
			if (cmd.set_cnt)
				cnt_q <= (32'(slot) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : slot;
			if (cmd.win_clr) begin
				wl_q <= '0;
				wf_q <= '0;
			end
			if (cmd.wl_inc)
				wl_q <= wl_q + CNT_W'(1);
			if (cmd.wf_inc)
				wf_q <= wf_q + CNT_W'(1);
			if (cmd.j_init)
				j_q <= CNT_W'(1);
			else if (cmd.j_inc)
				j_q <= j_q + CNT_W'(1);
			if (cmd.k_from_j)
				k_q <= j_q;
			else if (cmd.k_dec)
				k_q <= k_q - CNT_W'(1);
			else if (cmd.k_from_wf)
				k_q <= wf_q;
			else if (cmd.k_inc)
				k_q <= k_q + CNT_W'(1);
		end
	end

	// status
	assign line17  = {line_q[15], line_q};
	assign rd_y17  = {rd_q.y[15], rd_q.y};
	assign key_y17 = {key_q.y[15], key_q.y};
	assign y17     = rd_y17;
	assign row17   = line17 - y17;

	always_comb begin
		st            = '0;
		st.j_lt_cnt   = j_q < cnt_q;
		st.k_zero     = k_q == '0;
		st.key_before = (key_y17 < rd_y17) ||
			((key_y17 == rd_y17) && (key_q.depth < rd_q.depth));
		st.wl_lt_cnt  = wl_q < cnt_q;
		st.wf_lt_cnt  = wf_q < cnt_q;
		st.y_le_line  = y17 <= line17;
		st.y_le_lm16  = y17 <= (line17 - 17'sd16);
		st.k_lt_wl    = k_q < wl_q;
		st.cnt_zero   = cnt_q == '0;
		st.draw_ok    = (rd_q.depth != 8'd0) && (row17 >= 17'sd0) && (row17 <= 17'sd15) &&
			(32'(rd_q.spr) < NUM_SPRITES);
		st.out_busy   = out_valid_q && !out_ready;
	end

	always_comb begin
		for (int p = 0; p < 16; p++)
			mask_c[p] = {1'b0, pat_q[4*p +: 4]} != trn_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_pix || cmd.out_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_pix) begin
			x_start_q <= $signed({px_x_q[15], px_x_q}) + 17'sd16;
			colors_q  <= pat_q;
			mask_q    <= mask_c;
			bright_q  <= px_blink_q && phase_q;
			done_q    <= 1'b0;
		end else if (cmd.out_done) begin
			x_start_q <= '0;
			colors_q  <= '0;
			mask_q    <= '0;
			bright_q  <= 1'b0;
			done_q    <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign x_start    = x_start_q;
	assign colors     = colors_q;
	assign write_mask = mask_q;
	assign bright     = bright_q;
	assign done_res   = done_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= MAX_SLOTS)
		else $error("slot count out of range");
	a_wl_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wl_q) <= MAX_SLOTS)
		else $error("window end out of range");
	a_shift_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_shift |-> !st.k_zero)
		else $error("sort shift at slot zero");
endmodule
